FILE: rtl/sha256_stream_hasher_core_assert.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Concurrent checks clocked on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SHA_CHK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha256 core check failed");
// next-cycle implication
`define SHA_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha256 core check failed");
`else
`define SHA_CHK_NOW(lbl, ante, cons)
`define SHA_CHK_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and command/status structs of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	// message word in
	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        final_word;
	} msg_t;

	// digest word out
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	// byte source for the block append path
	localparam logic [2:0] SRC_IN    = 3'd0;
	localparam logic [2:0] SRC_PEND  = 3'd1;
	localparam logic [2:0] SRC_PAD   = 3'd2;
	localparam logic [2:0] SRC_ZERO  = 3'd3;
	localparam logic [2:0] SRC_LENHI = 3'd4;
	localparam logic [2:0] SRC_LENLO = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic       take_en;   // latch input word remainder, grow length
		logic [2:0] take_cnt;  // clamped byte count of the input word
		logic       app_en;    // append bytes to block
		logic [2:0] app_src;
		logic [2:0] app_n;     // bytes appended, 0 to 4
		logic       rnd_en;    // one compression round
		logic [5:0] rnd_idx;
		logic       fold_en;   // add working vars into chain value
		logic       clr_en;    // back to initial hash, zero length
		logic [2:0] out_idx;   // digest word on the output
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [5:0] fill;      // bytes held in the block
	} sts_t;

	localparam logic [0:7][31:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [0:63][31:0] SHA_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

FILE: rtl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 digest of a byte message fed as big-endian words of 0 to 4 bytes.
//
//   channel  dir  handshake             word
//   msg      in   msg_valid/msg_stall   data_word, valid_bytes, final_word
//   dig      out  dig_valid/dig_stall   digest_word, word_index, last_word
//
// A message word is taken only while idle; each filled 64-byte block runs
// 64 rounds in the single round unit, then the chain add, with msg_stall
// high, and a word that straddled the block then appends its remainder.
// The final word adds padding, up to 4 bytes at a time, and one or two blocks.
// The eight digest words then go out one per accepted cycle; msg_stall is
// high from acceptance of the final word until the eighth is taken.
// After reset the block holds the initial hash and accepts a word at once.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_stall,
	input  sha_pkg::msg_t msg_data,
	output logic          dig_valid,
	input  logic          dig_stall,
	output sha_pkg::dig_t dig_data
);
	import sha_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_data  (msg_data),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (msg_data.data_word),
		.cmd      (cmd),
		.sts      (sts),
		.dig_data (dig_data)
	);

endmodule

FILE: rtl/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Datapath: byte-append block register that doubles as the message schedule
// window, working variables, chain value, bit length and digest select.
// ----------------------------------------------------------------------------
module sha_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   in_word,
	input  sha_pkg::cmd_t cmd,
	output sha_pkg::sts_t sts,
	output sha_pkg::dig_t dig_data
);
	import sha_pkg::*;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	// block bytes in arrival order, newest in the low byte; word 0 on top when full
	logic [511:0]         blk_q;
	logic [511:0]         app_blk;
	logic [31:0]          pend_q;
	logic [31:0]          src_word;
	logic [63:0]          len_q;
	logic [5:0]           fill_q;
	logic [0:7][31:0]     h_q;
	logic [0:7][31:0]     v_q;
	logic [31:0]          w0, w1, w9, w14, w_new;
	logic [31:0]          t1, t2;

	// append source
	always_comb begin
		case (cmd.app_src)
			SRC_IN:    src_word = in_word;
			SRC_PEND:  src_word = pend_q;
			SRC_PAD:   src_word = 32'h8000_0000;
			SRC_LENHI: src_word = len_q[63:32];
			SRC_LENLO: src_word = len_q[31:0];
			default:   src_word = '0;
		endcase
	end

	// shift in the leading bytes of the source
	always_comb begin
		case (cmd.app_n)
			3'd0:    app_blk = blk_q;
			3'd1:    app_blk = {blk_q[503:0], src_word[31:24]};
			3'd2:    app_blk = {blk_q[495:0], src_word[31:16]};
			3'd3:    app_blk = {blk_q[487:0], src_word[31:8]};
			default: app_blk = {blk_q[479:0], src_word};
		endcase
	end

	// schedule window taps
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign w_new = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w9
		+ (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w0;

	// round function
	assign t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + SHA_K[cmd.rnd_idx] + w0;
	assign t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// block register and input remainder
	always_ff @(posedge clk) begin
		if (cmd.app_en) begin
			blk_q <= app_blk;
		end else if (cmd.rnd_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.take_en) begin
			pend_q <= in_word << {cmd.app_n, 3'b000};
		end
	end

	// fill, length, chain value and working vars
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			h_q    <= SHA_IV;
			v_q    <= SHA_IV;
		end else begin
			if (cmd.clr_en) begin
				fill_q <= '0;
				len_q  <= '0;
				h_q    <= SHA_IV;
				v_q    <= SHA_IV;
			end else begin
				if (cmd.app_en) begin
					fill_q <= fill_q + {3'b000, cmd.app_n};
				end
				if (cmd.take_en) begin
					len_q <= len_q + {58'd0, cmd.take_cnt, 3'b000};
				end
				if (cmd.rnd_en) begin
					v_q <= {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1,
						v_q[4], v_q[5], v_q[6]};
				end else if (cmd.fold_en) begin
					// vars restart from the new chain value
					for (int j = 0; j < 8; j++) begin
						h_q[j] <= h_q[j] + v_q[j];
						v_q[j] <= h_q[j] + v_q[j];
					end
				end
			end
		end
	end

	assign sts.fill = fill_q;

	assign dig_data.digest_word = h_q[cmd.out_idx];
	assign dig_data.word_index  = cmd.out_idx;
	assign dig_data.last_word   = (cmd.out_idx == 3'd7);

endmodule

FILE: rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller: input word intake, padding sequence, round counting and
// digest word sequencing.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_core_assert.svh"

module sha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_stall,
	input  sha_pkg::msg_t msg_data,
	output logic          dig_valid,
	input  logic          dig_stall,
	input  sha_pkg::sts_t sts,
	output sha_pkg::cmd_t cmd
);
	import sha_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COMP  = 3'd1;
	localparam logic [2:0] S_FOLD  = 3'd2;
	localparam logic [2:0] S_REM   = 3'd3;
	localparam logic [2:0] S_PAD80 = 3'd4;
	localparam logic [2:0] S_PADZ  = 3'd5;
	localparam logic [2:0] S_LENLO = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] res_q, res_d;      // where to go after the fold
	logic [2:0] rem_q, rem_d;      // bytes of the input word left for next block
	logic       fin_q, fin_d;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic [2:0] cnt, k, rem, zn, n_sel;
	logic [6:0] fill7, room, zt;
	logic       blk_full;

	// byte counts
	assign cnt   = (msg_data.valid_bytes > 3'd4) ? 3'd4 : msg_data.valid_bytes;
	assign fill7 = {1'b0, sts.fill};
	assign room  = 7'd64 - fill7;
	assign k     = ({4'b0000, cnt} <= room) ? cnt : room[2:0];
	assign rem   = cnt - k;
	assign zt    = (fill7 < 7'd56) ? (7'd56 - fill7) : (7'd64 - fill7);
	assign zn    = (zt >= 7'd4) ? 3'd4 : zt[2:0];

	// bytes appended this cycle
	always_comb begin
		case (state_q)
			S_IDLE:  n_sel = k;
			S_REM:   n_sel = rem_q;
			S_PAD80: n_sel = 3'd1;
			S_PADZ:  n_sel = (sts.fill == 6'd56) ? 3'd4 : zn;
			S_LENLO: n_sel = 3'd4;
			default: n_sel = 3'd0;
		endcase
	end

	assign blk_full = ((fill7 + {4'b0000, n_sel}) == 7'd64);

	// next state and commands
	always_comb begin
		logic [2:0] nxt;
		nxt      = msg_data.final_word ? S_PAD80 : S_IDLE;
		state_d  = state_q;
		res_d    = res_q;
		rem_d    = rem_q;
		fin_d    = fin_q;
		cmd          = '0;
		cmd.take_cnt = cnt;
		cmd.app_n    = n_sel;
		cmd.rnd_idx  = rnd_q;
		cmd.out_idx  = idx_q;
		case (state_q)
			S_IDLE: begin
				if (msg_valid) begin
					cmd.take_en = 1'b1;
					cmd.app_en  = 1'b1;
					cmd.app_src = SRC_IN;
					rem_d = rem;
					fin_d = msg_data.final_word;
					if (blk_full) begin
						res_d   = (rem != 3'd0) ? S_REM : nxt;
						state_d = S_COMP;
					end else begin
						state_d = nxt;
					end
				end
			end
			S_REM: begin
				cmd.app_en  = 1'b1;
				cmd.app_src = SRC_PEND;
				rem_d   = 3'd0;
				state_d = fin_q ? S_PAD80 : S_IDLE;
			end
			S_PAD80: begin
				cmd.app_en  = 1'b1;
				cmd.app_src = SRC_PAD;
				if (blk_full) begin
					res_d   = S_PADZ;
					state_d = S_COMP;
				end else begin
					state_d = S_PADZ;
				end
			end
			S_PADZ: begin
				cmd.app_en = 1'b1;
				if (sts.fill == 6'd56) begin
					cmd.app_src = SRC_LENHI;
					state_d     = S_LENLO;
				end else begin
					cmd.app_src = SRC_ZERO;
					if (blk_full) begin
						res_d   = S_PADZ;
						state_d = S_COMP;
					end
				end
			end
			S_LENLO: begin
				cmd.app_en  = 1'b1;
				cmd.app_src = SRC_LENLO;
				res_d   = S_OUT;
				state_d = S_COMP;
			end
			S_COMP: begin
				cmd.rnd_en = 1'b1;
				if (rnd_q == 6'd63) begin
					state_d = S_FOLD;
				end
			end
			S_FOLD: begin
				cmd.fold_en = 1'b1;
				state_d = res_q;
			end
			S_OUT: begin
				if (!dig_stall && idx_q == 3'd7) begin
					cmd.clr_en = 1'b1;
					fin_d   = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= S_IDLE;
			rem_q   <= '0;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			rem_q   <= rem_d;
			fin_q   <= fin_d;
			if (state_q == S_COMP) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == S_OUT && !dig_stall) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign msg_stall = (state_q != S_IDLE);
	assign dig_valid = (state_q == S_OUT);

	`SHA_CHK_NEXT(a_rnd_end, state_q == S_COMP && rnd_q == 6'd63, state_q == S_FOLD)
	`SHA_CHK_NEXT(a_fold_ret, state_q == S_FOLD, state_q == $past(res_q))
	`SHA_CHK_NOW(a_rem_aligned, state_q == S_REM, sts.fill == 6'd0 && rem_q != 3'd0)
	`SHA_CHK_NOW(a_len_slot, state_q == S_LENLO, sts.fill == 6'd60)

endmodule

FILE: sim/sha256_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches the message and digest channels of the SHA-256 stream hasher. It
// keeps its own running hash of every accepted message word, queues the eight
// digest words that each final word should produce, and compares each digest
// word taken from the core against the oldest one queued.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	input  logic          msg_stall,
	input  sha_pkg::msg_t msg_data,
	input  logic          dig_valid,
	input  logic          dig_stall,
	input  sha_pkg::dig_t dig_data,
	output int            mismatch_count,
	output int            digests_pending
);
	import sha_pkg::*;

	localparam logic [0:7][31:0] START_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// running hash of the message in flight
	logic [31:0] chain_h [8];
	logic [31:0] block_w [16];
	int          fill_bytes;
	logic [63:0] bit_len;

	// digest words still owed by the core, oldest first
	dig_t digest_q [$];

	initial begin
		mismatch_count  = 0;
		digests_pending = 0;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_message();
		for (int j = 0; j < 8; j++)
			chain_h[j] = START_HASH[j];
		for (int j = 0; j < 16; j++)
			block_w[j] = '0;
		fill_bytes = 0;
		bit_len    = '0;
	endfunction

	// 64 rounds over the full block, folded into the chain
	function automatic void compress_block();
		logic [31:0] sched [16];
		logic [31:0] v [8];
		logic [31:0] wt, s0, s1, t1, t2;
		for (int j = 0; j < 8; j++)
			v[j] = chain_h[j];
		for (int j = 0; j < 16; j++)
			sched[j] = block_w[j];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wt = sched[r];
			end else begin
				s1 = rotr(sched[(r - 2) & 15], 17) ^ rotr(sched[(r - 2) & 15], 19)
					^ (sched[(r - 2) & 15] >> 10);
				s0 = rotr(sched[(r - 15) & 15], 7) ^ rotr(sched[(r - 15) & 15], 18)
					^ (sched[(r - 15) & 15] >> 3);
				wt = s1 + sched[(r - 7) & 15] + s0 + sched[r & 15];
				sched[r & 15] = wt;
			end
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wt;
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			chain_h[j] = chain_h[j] + v[j];
	endfunction

	function automatic void push_octet(input logic [7:0] b8);
		block_w[fill_bytes >> 2][31 - 8 * (fill_bytes & 3) -: 8] = b8;
		fill_bytes++;
		if (fill_bytes == 64) begin
			compress_block();
			fill_bytes = 0;
		end
	endfunction

	// absorb one message word; a final word pads and queues the digest
	function automatic void absorb_word(input msg_t w);
		int          n_bytes;
		logic [63:0] len_snap;
		dig_t        d;
		n_bytes = (w.valid_bytes > 3'd4) ? 4 : int'(w.valid_bytes);
		for (int i = 0; i < n_bytes; i++) begin
			push_octet(w.data_word[31 - 8 * i -: 8]);
			bit_len = bit_len + 64'd8;
		end
		if (w.final_word) begin
			len_snap = bit_len;
			push_octet(8'h80);
			while (fill_bytes != 56)
				push_octet(8'h00);
			for (int i = 0; i < 8; i++)
				push_octet(len_snap[63 - 8 * i -: 8]);
			for (int i = 0; i < 8; i++) begin
				d.digest_word = chain_h[i];
				d.word_index  = 3'(i);
				d.last_word   = (i == 7);
				digest_q.insert(digest_q.size(), d);
			end
			restart_message();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] digest channel: %s, got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_digest_word(input dig_t got);
		dig_t want;
		if (digest_q.size() == 0) begin
			report_mismatch("word with none expected", got.digest_word, '0);
		end else begin
			want = digest_q.pop_front();
			if (got.digest_word !== want.digest_word)
				report_mismatch("digest_word", got.digest_word, want.digest_word);
			if (got.word_index !== want.word_index)
				report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
			if (got.last_word !== want.last_word)
				report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
		end
	endtask

	// sample both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_message();
			digest_q.delete();
			digests_pending = 0;
		end else begin
			if (dig_valid && !dig_stall)
				check_digest_word(dig_data);
			if (msg_valid && !msg_stall)
				absorb_word(msg_data);
			digests_pending = digest_q.size();
		end
	end

endmodule

FILE: sim/tb_sha256_stream_hasher_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_core
// Feeds the SHA-256 stream hasher with directed messages (empty message,
// short and oversized byte counts, padding that spills into a second block)
// and then random messages; both channels stall at random in the first two of
// three phases. The checker beside the core predicts and compares every digest.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_core;
	import sha_pkg::*;

	localparam int RANDOM_WORDS = 270;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic msg_valid;
	logic msg_stall;
	msg_t msg_data;
	logic dig_valid;
	logic dig_stall;
	dig_t dig_data;

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	int digests_pending;
	int cycle_count;
	int words_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	sha256_stream_hasher_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_data  (msg_data),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig_data  (dig_data)
	);

	sha256_digest_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.msg_valid       (msg_valid),
		.msg_stall       (msg_stall),
		.msg_data        (msg_data),
		.dig_valid       (dig_valid),
		.dig_stall       (dig_stall),
		.dig_data        (dig_data),
		.mismatch_count  (mismatch_count),
		.digests_pending (digests_pending)
	);

	// digest side back-pressure
	always @(negedge clk) begin
		dig_stall <= ($urandom_range(99, 0) < recv_idle_pct);
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// offer one word, with random gaps ahead of it; returns at the falling edge
	// after it was taken
	task automatic send_word(input msg_t w);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid <= 1'b1;
		msg_data  <= w;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [31:0] data, input logic [2:0] n_bytes,
		input logic last);
		msg_t w;
		w.data_word   = data;
		w.valid_bytes = n_bytes;
		w.final_word  = last;
		send_word(w);
	endtask

	// random message: mostly full words, some short, empty or oversized counts
	task automatic send_random_message();
		int   n_words;
		int   pick;
		msg_t w;
		n_words = ($urandom_range(99, 0) < 85) ? $urandom_range(20, 1)
			: $urandom_range(40, 21);
		for (int i = 0; i < n_words; i++) begin
			w.data_word  = $urandom();
			w.final_word = (i == n_words - 1);
			pick = $urandom_range(99, 0);
			if (w.final_word)
				w.valid_bytes = 3'($urandom_range(7, 0));
			else if (pick < 75)
				w.valid_bytes = 3'd4;
			else if (pick < 85)
				w.valid_bytes = 3'($urandom_range(7, 5));
			else if (pick < 95)
				w.valid_bytes = 3'($urandom_range(3, 1));
			else
				w.valid_bytes = 3'd0;
			send_word(w);
			words_sent++;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		msg_valid     = 1'b0;
		msg_data      = '0;
		dig_stall     = 1'b0;
		send_idle_pct = 28;
		recv_idle_pct = 62;
		words_sent    = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message
		send_fields(32'h0000_0000, 3'd0, 1'b1);
		// "abc"
		send_fields(32'h6162_6300, 3'd3, 1'b1);
		// oversized counts, an empty word mid-message, oversized final
		send_fields(32'hffff_ffff, 3'd7, 1'b0);
		send_fields(32'h0000_0000, 3'd5, 1'b0);
		send_fields(32'h1234_5678, 3'd0, 1'b0);
		send_fields(32'ha5a5_a5a5, 3'd6, 1'b1);
		// short words that are not final, byte-granular stream
		send_fields(32'h1122_3344, 3'd1, 1'b0);
		send_fields(32'h5566_7788, 3'd2, 1'b0);
		send_fields(32'h99aa_bbcc, 3'd3, 1'b1);
		// 56 bytes: the length no longer fits, padding spills into a new block
		for (int i = 0; i < 14; i++)
			send_fields(i[0] ? 32'hffff_ffff : 32'h0000_0000, 3'd4, 1'b0);
		send_fields(32'hdead_beef, 3'd0, 1'b1);

		// random messages in three phases, the last without stalls
		while (words_sent < RANDOM_WORDS) begin
			if (words_sent < RANDOM_WORDS / 3) begin
				send_idle_pct = 28;
				recv_idle_pct = 62;
			end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
				send_idle_pct = 62;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_random_message();
		end
		msg_valid <= 1'b0;

		// drain the outstanding digests, then let the core settle
		while (digests_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
